// ===== src/c3rb_pkg.sv =====
// shared constants, types and register codes for the 3x3 replicate-border convolution
// no dependencies; the other files that use this package refer to it by scoped names
`default_nettype none

package c3rb_pkg;

    localparam int MAX_WIDTH     = 1024;
    localparam int PIXEL_BITS    = 8;
    localparam int COEF_BITS     = 8;
    localparam int ADDR_BITS     = $clog2(MAX_WIDTH);
    localparam int WIDTH_BITS    = $clog2(MAX_WIDTH + 1);
    localparam int HEIGHT_BITS   = 16;
    localparam int VALUE_BITS    = 20;
    localparam int KERNEL_BITS   = 3 * COEF_BITS;
    localparam int CFG_DATA_BITS = 24;
    localparam int CFG_IDX_BITS  = 3;
    localparam int PROD_BITS     = PIXEL_BITS + 1 + COEF_BITS;

    localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_TOP   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_MID   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_BOT   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 3'd4;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    localparam logic [WIDTH_BITS-1:0]  MAX_WIDTH_W = WIDTH_BITS'(MAX_WIDTH);
    localparam logic [HEIGHT_BITS-1:0] ROW_CAP     = '1;

    typedef logic [PIXEL_BITS-1:0]         pixel_t;
    typedef logic [KERNEL_BITS-1:0]        kernel_row_t;
    typedef logic signed [VALUE_BITS-1:0]  value_t;

    // which neighbours fall outside the image and take the centre instead
    typedef struct packed {
        logic top;
        logic bot;
        logic left;
        logic right;
    } border_t;

endpackage

`default_nettype wire

// ===== src/c3rb_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module c3rb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/c3rb_mac.sv =====
// nine multiplies and the sum over the 3x3 window, with replicate border selection
// depends on c3rb_pkg
`default_nettype none

module c3rb_mac (
    input  wire c3rb_pkg::pixel_t      win [0:8],
    input  wire c3rb_pkg::border_t     border,
    input  wire c3rb_pkg::kernel_row_t kernel [0:2],
    output c3rb_pkg::value_t           sum
);

    always_comb
    begin
        logic signed [c3rb_pkg::PIXEL_BITS:0]    px;
        logic signed [c3rb_pkg::COEF_BITS-1:0]   cf;
        logic signed [c3rb_pkg::PROD_BITS-1:0]   prod;
        c3rb_pkg::value_t                        acc;
        int                                      rl;
        int                                      cm;
        acc = '0;
        for (int l = 0; l < 3; l++)
        begin
            for (int m = 0; m < 3; m++)
            begin
                rl = l;
                cm = m;
                if (l == 0 && border.top)   rl = 1;
                if (l == 2 && border.bot)   rl = 1;
                if (m == 0 && border.left)  cm = 1;
                if (m == 2 && border.right) cm = 1;
                px   = $signed({1'b0, win[rl * 3 + cm]});
                cf   = $signed(kernel[l][m * c3rb_pkg::COEF_BITS +: c3rb_pkg::COEF_BITS]);
                prod = px * cf;
                acc  = acc + c3rb_pkg::VALUE_BITS'(prod);
            end
        end
        sum = acc;
    end

endmodule

`default_nettype wire

// ===== src/conv3x3_replicate_border_top.sv =====
// top level of the streaming 3x3 convolution with replicate border
// depends on c3rb_pkg, c3rb_ram and c3rb_mac
`default_nettype none

// Raster-order 3x3 convolution with signed 8-bit kernel and replicate padding.
// Takes one item per clock when the result side keeps up; after its trigger
// item is accepted, a result passes the stage register, then the output
// register. The output for pixel n is triggered by item n+width+1; after the
// frame, drain items flush the last width+1 outputs and the final one carries
// last. The rate is set by the two line-store rams (one read and one write per
// item each) and the single multiply-add stage behind them. The stores are not
// cleared after reset; the border rule keeps unwritten entries away from every
// result. Program the kernel, width and height only while no item is in flight.
module conv3x3_replicate_border_top (
    input  wire  logic                                 clk,
    input  wire  logic                                 rst_n,
    input  wire  logic                                 cfg_write,
    input  wire  logic [c3rb_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire  logic [c3rb_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  wire  logic                                 in_valid,
    output logic                                       in_ready,
    input  wire  logic                                 action,
    input  wire  c3rb_pkg::pixel_t                     pixel,
    output logic                                       out_valid,
    input  wire  logic                                 out_ready,
    output c3rb_pkg::value_t                           value,
    output logic [c3rb_pkg::HEIGHT_BITS-1:0]           out_row,
    output logic [c3rb_pkg::ADDR_BITS-1:0]             out_col,
    output logic                                       last
);

    // configuration
    c3rb_pkg::kernel_row_t                  kernel_reg [0:2];
    logic [c3rb_pkg::WIDTH_BITS-1:0]        width_reg;
    logic [c3rb_pkg::HEIGHT_BITS-1:0]       height_reg;
    logic [c3rb_pkg::WIDTH_BITS-1:0]        eff_w;
    logic [c3rb_pkg::HEIGHT_BITS-1:0]       eff_h;

    // position counters
    logic [c3rb_pkg::HEIGHT_BITS-1:0]       in_row_reg,  in_row_next;
    logic [c3rb_pkg::ADDR_BITS-1:0]         in_col_reg,  in_col_next;
    logic [c3rb_pkg::HEIGHT_BITS-1:0]       out_row_reg, out_row_next;
    logic [c3rb_pkg::ADDR_BITS-1:0]         out_col_reg, out_col_next;

    // decode of the item at the input
    logic                                   accept;
    logic                                   beyond;
    logic                                   skip;
    logic                                   load;
    logic                                   col_wrap;
    logic                                   early;
    logic                                   emit;
    logic                                   ocol_wrap;
    logic                                   orow_end;
    logic                                   is_last;
    c3rb_pkg::pixel_t                       new_pix;

    // stage after the input: ram data arrives here
    logic                                   s1_valid_reg, s1_valid_next;
    logic                                   s1_go;
    logic                                   s1_emit_reg;
    logic                                   s1_last_reg;
    logic [c3rb_pkg::ADDR_BITS-1:0]         s1_addr_reg;
    c3rb_pkg::pixel_t                       s1_pix_reg;
    logic [c3rb_pkg::HEIGHT_BITS-1:0]       s1_row_reg;
    logic [c3rb_pkg::ADDR_BITS-1:0]         s1_col_reg;
    c3rb_pkg::border_t                      s1_border_reg;
    c3rb_pkg::border_t                      border;

    // line stores and read-after-write forwarding
    logic                                   wr_en;
    c3rb_pkg::pixel_t                       upper_rd;
    c3rb_pkg::pixel_t                       lower_rd;
    c3rb_pkg::pixel_t                       upper_eff;
    c3rb_pkg::pixel_t                       lower_eff;
    logic                                   byp_reg;
    c3rb_pkg::pixel_t                       byp_upper_reg;
    c3rb_pkg::pixel_t                       byp_lower_reg;

    // window
    c3rb_pkg::pixel_t                       win_reg  [0:8];
    c3rb_pkg::pixel_t                       win_next [0:8];
    c3rb_pkg::value_t                       sum;

    // result register
    logic                                   out_valid_reg, out_valid_next;
    c3rb_pkg::value_t                       value_reg;
    logic [c3rb_pkg::HEIGHT_BITS-1:0]       out_row_reg_q;
    logic [c3rb_pkg::ADDR_BITS-1:0]         out_col_reg_q;
    logic                                   last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_reg[0] <= '0;
            kernel_reg[1] <= '0;
            kernel_reg[2] <= '0;
            width_reg     <= c3rb_pkg::WIDTH_BITS'(1);
            height_reg    <= c3rb_pkg::HEIGHT_BITS'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                c3rb_pkg::REG_KERNEL_TOP:   kernel_reg[0] <= cfg_data[c3rb_pkg::KERNEL_BITS-1:0];
                c3rb_pkg::REG_KERNEL_MID:   kernel_reg[1] <= cfg_data[c3rb_pkg::KERNEL_BITS-1:0];
                c3rb_pkg::REG_KERNEL_BOT:   kernel_reg[2] <= cfg_data[c3rb_pkg::KERNEL_BITS-1:0];
                c3rb_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data[c3rb_pkg::WIDTH_BITS-1:0];
                c3rb_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data[c3rb_pkg::HEIGHT_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == '0)
            eff_w = c3rb_pkg::WIDTH_BITS'(1);
        else if (width_reg > c3rb_pkg::MAX_WIDTH_W)
            eff_w = c3rb_pkg::MAX_WIDTH_W;
        else
            eff_w = width_reg;
        eff_h = (height_reg == '0) ? c3rb_pkg::HEIGHT_BITS'(1) : height_reg;
    end

    // handshake and decode
    assign s1_go    = !s1_emit_reg || !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s1_go;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        beyond    = in_row_reg >= eff_h;
        skip      = (action == c3rb_pkg::ACT_DRAIN) && !beyond;
        load      = accept && !skip;
        new_pix   = beyond ? '0 : pixel;
        col_wrap  = ({1'b0, in_col_reg} + c3rb_pkg::WIDTH_BITS'(1)) >= eff_w;
        // outputs start once width+1 items have gone in
        early     = ((in_row_reg == '0) && ({1'b0, in_col_reg} <= eff_w))
                 || ((in_row_reg == c3rb_pkg::HEIGHT_BITS'(1)) && (in_col_reg == '0));
        emit      = !early;
        ocol_wrap = ({1'b0, out_col_reg} + c3rb_pkg::WIDTH_BITS'(1)) >= eff_w;
        orow_end  = ({1'b0, out_row_reg} + 17'd1) >= {1'b0, eff_h};
        is_last   = orow_end && ocol_wrap;

        border.top   = (out_row_reg == '0);
        border.bot   = orow_end;
        border.left  = (out_col_reg == '0);
        border.right = ocol_wrap;

        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        if (load)
        begin
            if (col_wrap)
            begin
                in_col_next = '0;
                if (in_row_reg != c3rb_pkg::ROW_CAP)
                    in_row_next = in_row_reg + c3rb_pkg::HEIGHT_BITS'(1);
            end
            else
            begin
                in_col_next = in_col_reg + c3rb_pkg::ADDR_BITS'(1);
            end
            if (emit)
            begin
                if (is_last)
                begin
                    in_row_next  = '0;
                    in_col_next  = '0;
                    out_row_next = '0;
                    out_col_next = '0;
                end
                else if (ocol_wrap)
                begin
                    out_col_next = '0;
                    if (out_row_reg != c3rb_pkg::ROW_CAP)
                        out_row_next = out_row_reg + c3rb_pkg::HEIGHT_BITS'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + c3rb_pkg::ADDR_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
        end
        else
        begin
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
        end
    end

    assign s1_valid_next = load ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (load)
                s1_emit_reg <= emit;
            else if (s1_go)
                s1_emit_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_last_reg   <= is_last;
            s1_addr_reg   <= in_col_reg;
            s1_pix_reg    <= new_pix;
            s1_row_reg    <= out_row_reg;
            s1_col_reg    <= out_col_reg;
            s1_border_reg <= border;
            // same column read while it is being written: take the new data
            byp_reg       <= wr_en && (s1_addr_reg == in_col_reg);
            byp_upper_reg <= lower_eff;
            byp_lower_reg <= s1_pix_reg;
        end
    end

    assign wr_en     = s1_valid_reg && s1_go;
    assign upper_eff = byp_reg ? byp_upper_reg : upper_rd;
    assign lower_eff = byp_reg ? byp_lower_reg : lower_rd;

    c3rb_ram #(
        .WIDTH (c3rb_pkg::PIXEL_BITS),
        .DEPTH (c3rb_pkg::MAX_WIDTH)
    ) u_upper (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_addr_reg),
        .wdata (lower_eff),
        .re    (load),
        .raddr (in_col_reg),
        .rdata (upper_rd)
    );

    c3rb_ram #(
        .WIDTH (c3rb_pkg::PIXEL_BITS),
        .DEPTH (c3rb_pkg::MAX_WIDTH)
    ) u_lower (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_addr_reg),
        .wdata (s1_pix_reg),
        .re    (load),
        .raddr (in_col_reg),
        .rdata (lower_rd)
    );

    // window shifts left, new column enters on the right
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_next[r * 3]     = win_reg[r * 3 + 1];
            win_next[r * 3 + 1] = win_reg[r * 3 + 2];
        end
        win_next[2] = upper_eff;
        win_next[5] = lower_eff;
        win_next[8] = s1_pix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
        end
        else if (wr_en)
        begin
            for (int i = 0; i < 9; i++)
                win_reg[i] <= win_next[i];
        end
    end

    c3rb_mac u_mac (
        .win    (win_next),
        .border (s1_border_reg),
        .kernel (kernel_reg),
        .sum    (sum)
    );

    always_comb
    begin
        if (wr_en && s1_emit_reg)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && s1_emit_reg)
        begin
            value_reg     <= sum;
            out_row_reg_q <= s1_row_reg;
            out_col_reg_q <= s1_col_reg;
            last_reg      <= s1_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign out_row   = out_row_reg_q;
    assign out_col   = out_col_reg_q;
    assign last      = last_reg;

endmodule

`default_nettype wire

// ===== src/c3rb_checker.sv =====
// port-level checks on the result stream of the convolution top level
// depends on c3rb_pkg; bound to conv3x3_replicate_border_top below
`default_nettype none

module c3rb_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               out_valid,
    input wire logic                               out_ready,
    input wire c3rb_pkg::value_t                   value,
    input wire logic [c3rb_pkg::HEIGHT_BITS-1:0]   out_row,
    input wire logic [c3rb_pkg::ADDR_BITS-1:0]     out_col,
    input wire logic                               last
);

    // a stalled item holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value) && $stable(out_row)
            && $stable(out_col) && $stable(last))
        else $error("result changed while stalled");

    // the frame restarts after last, so no result can follow at once
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last |=> !out_valid)
        else $error("result right after end of frame");

    // columns step by one or wrap to zero
    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last ##1 out_valid)
            |-> (out_col == c3rb_pkg::ADDR_BITS'($past(out_col) + 1'b1)) || (out_col == '0))
        else $error("output column out of order");

    // the row changes only on a column wrap
    a_row_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last ##1 out_valid && out_col != '0)
            |-> out_row == $past(out_row))
        else $error("output row changed mid-row");

endmodule

bind conv3x3_replicate_border_top c3rb_checker u_checker (.*);

`default_nettype wire
